// File: sv/i2crm_pkg.sv
// Shared types, constants and the pointer-to-index table of the I2C register map.
package i2crm_pkg;

	localparam int MEM_DEPTH = 256;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [7:0] UPDATE_OFFSET = 8'h42;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_INIT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NONE       = 2'd0,
		KIND_WRITE_DONE = 2'd1,
		KIND_READ_PEND  = 2'd2,
		KIND_READ_DONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READY = 2'd1,
		PH_TX    = 2'd2,
		PH_RX    = 2'd3
	} phase_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		logic              re;
		logic [MEM_AW-1:0] raddr;
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef logic [MEM_AW-1:0] idx_lut_t [256];

	// 8-bit pointer to memory index, worked out at elaboration
	function automatic idx_lut_t build_idx_lut();
		idx_lut_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = MEM_AW'(i % MEM_DEPTH);
		end
		return t;
	endfunction

	localparam idx_lut_t MEM_IDX_LUT = build_idx_lut();

endpackage

// File: sv/i2crm_ifs.sv
// Valid/ready channel interfaces for bus events and result words.
interface i2crm_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_in;

	modport source (output valid, output command, output data_in, input ready);
	modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface i2crm_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [1:0] event_kind;
	logic [7:0] event_offset;
	logic [7:0] event_length;
	logic [7:0] own_address;
	logic       address_updated;

	modport source (output valid, output read_data, output event_kind, output event_offset,
		output event_length, output own_address, output address_updated, input ready);
	modport sink   (input valid, input read_data, input event_kind, input event_offset,
		input event_length, input own_address, input address_updated, output ready);
endinterface

// File: sv/i2c_slave_register_map.sv
// Top level of the I2C target register map back end.
//
//   channel   dir   handshake      words
//   evt       in    valid/ready    command, data_in
//   res       out   valid/ready    read_data, event_kind, event_offset,
//                                  event_length, own_address, address_updated
//   cfg       in    cfg_we         cfg_wdata (initial own address)
//
// Each event word is handled in an accept cycle, which issues the memory read,
// and an execute cycle, which modifies state, writes memory and loads the result register.
// The execute cycle uses the registered read data of the register memory.
// Reset clears the memory at once through per-entry valid bits.
// A waiting result does not block the next accept; that word holds in the
// execute cycle until the result register frees.
module i2c_slave_register_map (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	i2crm_evt_if.sink  evt,
	i2crm_res_if.source res
);

	i2crm_pkg::mem_req_t mem_req;
	logic [7:0]          mem_rdata;

	i2crm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt       (evt),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	i2crm_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

endmodule

// File: sv/i2crm_mem.sv
// Register memory: synchronous read, one write port, per-entry valid bits cleared at reset.
module i2crm_mem (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2crm_pkg::mem_req_t  req,
	output logic [7:0]           rdata
);

	logic [7:0]                     mem [i2crm_pkg::MEM_DEPTH];
	logic [i2crm_pkg::MEM_DEPTH-1:0] vld_q;
	logic [7:0]                     rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= vld_q[req.raddr] ? mem[req.raddr] : 8'd0;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/i2crm_ctrl.sv
// Transfer sequencer: pointer, phase, own address and the result word register.
module i2crm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_wdata,
	i2crm_evt_if.sink            evt,
	i2crm_res_if.source          res,
	output i2crm_pkg::mem_req_t  mem_req,
	input  logic [7:0]           mem_rdata
);

	i2crm_pkg::fsm_t   fsm_q, fsm_d;
	i2crm_pkg::phase_t phase_q, phase_d;
	i2crm_pkg::cmd_t   cmd_q;
	logic [7:0]        data_q;
	logic [7:0]        ptr_q, ptr_d;
	logic [7:0]        start_q, start_d;
	logic [7:0]        target_q, target_d;

	logic              out_vld_q;
	logic [7:0]        rd_q, off_q, len_q;
	i2crm_pkg::kind_t  kind_q;
	logic              upd_q;

	logic [7:0]        rd_d, off_d, len_d;
	i2crm_pkg::kind_t  kind_d;
	logic              upd_d;

	logic              accept, fire, slot_free;
	logic [7:0]        wlen, rlen;

	assign evt.ready = (fsm_q == i2crm_pkg::FSM_IDLE);
	assign accept    = evt.valid && evt.ready;
	assign slot_free = !out_vld_q || res.ready;
	assign fire      = (fsm_q == i2crm_pkg::FSM_EXEC) && slot_free;
	assign wlen      = ptr_q - start_q;
	assign rlen      = ptr_q - start_q - 8'd1;

	always_comb begin
		fsm_d         = fsm_q;
		phase_d       = phase_q;
		ptr_d         = ptr_q;
		start_d       = start_q;
		target_d      = target_q;
		rd_d          = 8'd0;
		kind_d        = i2crm_pkg::KIND_NONE;
		off_d         = 8'd0;
		len_d         = 8'd0;
		upd_d         = 1'b0;
		mem_req.re    = accept;
		// a stop fetches the own-address byte, everything else the pointed byte
		mem_req.raddr = (i2crm_pkg::cmd_t'(evt.command) == i2crm_pkg::CMD_STOP) ?
			i2crm_pkg::MEM_IDX_LUT[i2crm_pkg::UPDATE_OFFSET] : i2crm_pkg::MEM_IDX_LUT[ptr_q];
		mem_req.we    = 1'b0;
		mem_req.waddr = i2crm_pkg::MEM_IDX_LUT[ptr_q];
		mem_req.wdata = data_q;

		unique case (fsm_q)
			i2crm_pkg::FSM_IDLE: begin
				if (accept) begin
					fsm_d = i2crm_pkg::FSM_EXEC;
				end
			end
			i2crm_pkg::FSM_EXEC: begin
				if (fire) begin
					fsm_d = i2crm_pkg::FSM_IDLE;
					unique case (cmd_q)
						i2crm_pkg::CMD_WRITE: begin
							if (phase_q == i2crm_pkg::PH_IDLE) begin
								ptr_d   = data_q;
								start_d = data_q;
								phase_d = i2crm_pkg::PH_READY;
							end else begin
								phase_d    = i2crm_pkg::PH_RX;
								mem_req.we = 1'b1;
								ptr_d      = ptr_q + 8'd1;
							end
						end
						i2crm_pkg::CMD_READ: begin
							phase_d = i2crm_pkg::PH_TX;
							rd_d    = mem_rdata;
							ptr_d   = ptr_q + 8'd1;
						end
						i2crm_pkg::CMD_STOP: begin
							unique case (phase_q)
								i2crm_pkg::PH_IDLE: begin
								end
								i2crm_pkg::PH_READY: begin
									// keep pointer for a repeated-start read
									kind_d = i2crm_pkg::KIND_READ_PEND;
									off_d  = start_q;
								end
								i2crm_pkg::PH_RX: begin
									kind_d = i2crm_pkg::KIND_WRITE_DONE;
									off_d  = start_q;
									len_d  = wlen;
									if (start_q == i2crm_pkg::UPDATE_OFFSET && wlen != 8'd0) begin
										target_d = mem_rdata;
										upd_d    = 1'b1;
									end
									phase_d = i2crm_pkg::PH_IDLE;
									ptr_d   = 8'd0;
									start_d = 8'd0;
								end
								i2crm_pkg::PH_TX: begin
									kind_d  = i2crm_pkg::KIND_READ_DONE;
									off_d   = start_q;
									len_d   = rlen;
									phase_d = i2crm_pkg::PH_IDLE;
									ptr_d   = 8'd0;
									start_d = 8'd0;
								end
								default: begin
								end
							endcase
						end
						i2crm_pkg::CMD_INIT: begin
							phase_d = i2crm_pkg::PH_IDLE;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				fsm_d = i2crm_pkg::FSM_IDLE;
			end
		endcase

		if (cfg_we) begin
			target_d = {1'b0, cfg_wdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= i2crm_pkg::FSM_IDLE;
			phase_q   <= i2crm_pkg::PH_IDLE;
			ptr_q     <= 8'd0;
			start_q   <= 8'd0;
			target_q  <= 8'd0;
			out_vld_q <= 1'b0;
		end else begin
			fsm_q    <= fsm_d;
			phase_q  <= phase_d;
			ptr_q    <= ptr_d;
			start_q  <= start_d;
			target_q <= target_d;
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// hold the event word for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= i2crm_pkg::cmd_t'(evt.command);
			data_q <= evt.data_in;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_q   <= rd_d;
			kind_q <= kind_d;
			off_q  <= off_d;
			len_q  <= len_d;
			upd_q  <= upd_d;
		end
	end

	assign res.valid           = out_vld_q;
	assign res.read_data       = rd_q;
	assign res.event_kind      = kind_q;
	assign res.event_offset    = off_q;
	assign res.event_length    = len_q;
	assign res.own_address     = target_q;
	assign res.address_updated = upd_q;

endmodule
